// ===== rtl/b64e_pkg.sv =====
// shared types, constants and the sextet to ascii mapping of the base64 encoder
package b64e_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned GROUP_W     = 24;

  localparam logic [CHAR_W-1:0] PAD_CHAR = 7'd61;

  localparam logic [1:0] NB_ONE   = 2'd1;
  localparam logic [1:0] NB_TWO   = 2'd2;
  localparam logic [1:0] NB_THREE = 2'd3;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  // one group of up to three bytes, zero filled, ready for encoding
  typedef struct packed {
    logic [GROUP_W-1:0] group;
    logic [1:0]         nbytes;
    logic               last;
  } group_t;

  function automatic logic [CHAR_W-1:0] sextet_char(input logic [5:0] s);
    logic [CHAR_W-1:0] c;
    c = 7'd47;
    if (s < 6'd26) begin
      c = 7'd65 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'd71 + {1'b0, s};
    end else if (s < 6'd62) begin
      c = {1'b0, s} - 7'd4;
    end else if (s == 6'd62) begin
      c = 7'd43;
    end
    return c;
  endfunction

endpackage

// ===== rtl/base64_stream_encoder_unit.sv =====
// top level of the streaming base64 encoder
//
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_byte[7:0], in_last
//   out_      output     out_valid / out_ready out_char[6:0], out_last
//
// each closed group of bytes gives four characters from the output register, one per cycle unless out_ready stalls
// sustained byte rate is set by the one-character-per-cycle back end
// a byte that does not close a group is taken while the queue has room
// the closing byte is written into the queue, and its first character then loads the output register
// rst_n is synchronous; it clears held bytes, the queue, the output valid flag and the group position
// out_ready low stalls the back end; the front keeps taking bytes until the queue fills
module base64_stream_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_byte,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [b64e_pkg::CHAR_W-1:0]   out_char,
  output logic                          out_last
);

  logic             push_valid, push_ready;
  b64e_pkg::group_t push_data;
  logic             pop_valid, pop_ready;
  b64e_pkg::group_t pop_data;

  b64e_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  b64e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule

// ===== rtl/b64e_front.sv =====
// front end: gathers bytes into groups of three and closes short final groups
module b64e_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output logic                   push_valid,
  input  logic                   push_ready,
  output b64e_pkg::group_t       push_data
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        fire;
  logic        close_group;

  assign close_group = (cnt_r == b64e_pkg::NB_TWO) || in_last;
  assign push_valid  = in_valid && close_group;
  assign in_ready    = push_ready;
  assign fire        = in_valid && in_ready;

  always_comb begin
    push_data.last = in_last;
    unique case (cnt_r)
      2'd2: begin
        push_data.group  = {pend_r, in_byte};
        push_data.nbytes = b64e_pkg::NB_THREE;
      end
      2'd1: begin
        push_data.group  = {pend_r[7:0], in_byte, 8'h00};
        push_data.nbytes = b64e_pkg::NB_TWO;
      end
      default: begin
        push_data.group  = {in_byte, 16'h0000};
        push_data.nbytes = b64e_pkg::NB_ONE;
      end
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      if (close_group) begin
        pend_nxt = 16'h0000;
        cnt_nxt  = 2'd0;
      end else begin
        pend_nxt = {pend_r[7:0], in_byte};
        cnt_nxt  = cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 16'h0000;
      cnt_r  <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("held byte count out of range");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_last) |=> (cnt_r == 2'd0)) else $error("state not cleared after last");
  a_push_on_third: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cnt_r == b64e_pkg::NB_TWO) |-> (push_data.nbytes == b64e_pkg::NB_THREE))
    else $error("full group not pushed");
`endif

endmodule

// ===== rtl/b64e_queue.sv =====
// short register queue of byte groups between front and back end
module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  b64e_pkg::group_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output b64e_pkg::group_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64e_pkg::group_t   mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH)) else $error("queue overfilled");
  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("queue count lost a push");
  a_ptrs_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r)) else $error("queue pointers diverged");
`endif

endmodule

// ===== rtl/b64e_back.sv =====
// back end: four characters per queued group, one per cycle unless stalled
module b64e_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            pop_valid,
  output logic                            pop_ready,
  input  b64e_pkg::group_t                pop_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [b64e_pkg::CHAR_W-1:0]     out_char,
  output logic                            out_last
);

  logic [1:0]                    pos_r, pos_nxt;
  logic                          valid_r, valid_nxt;
  logic [b64e_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic                          last_r, last_nxt;
  logic                          load;
  logic                          emit;

  assign load      = !valid_r || out_ready;
  assign emit      = load && pop_valid;
  assign pop_ready = load && (pos_r == b64e_pkg::POS_FOURTH);

  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  always_comb begin
    unique case (pos_r)
      2'd0: char_nxt = b64e_pkg::sextet_char(pop_data.group[23:18]);
      2'd1: char_nxt = b64e_pkg::sextet_char(pop_data.group[17:12]);
      2'd2: char_nxt = (pop_data.nbytes != b64e_pkg::NB_ONE)
                       ? b64e_pkg::sextet_char(pop_data.group[11:6]) : b64e_pkg::PAD_CHAR;
      default: char_nxt = (pop_data.nbytes == b64e_pkg::NB_THREE)
                          ? b64e_pkg::sextet_char(pop_data.group[5:0]) : b64e_pkg::PAD_CHAR;
    endcase
    last_nxt = pop_data.last && (pos_r == b64e_pkg::POS_FOURTH);
  end

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = pop_valid;
      if (pop_valid) begin
        pos_nxt = pos_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      char_r <= char_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= b64e_pkg::POS_FIRST;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_early_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && (pos_r == b64e_pkg::POS_FIRST || pos_r == b64e_pkg::POS_SECOND))
    |=> (char_r != b64e_pkg::PAD_CHAR)) else $error("padding in leading position");
  a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pos_r != b64e_pkg::POS_FOURTH) |=> !last_r) else $error("last flag too early");
  a_group_done: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pos_r == b64e_pkg::POS_FOURTH) |=> (pos_r == b64e_pkg::POS_FIRST))
    else $error("group position did not wrap");
`endif

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the streaming base64 encoder: directed table, then random messages
module tb_top;

  localparam int unsigned RAND_ITEMS = 250;
  localparam int unsigned IDLE_PCT   = 36;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [b64e_pkg::CHAR_W-1:0] ch;
    logic                        lst;
  } enc_char_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        l;
    logic        typed;
    logic [31:0] chars;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] in_byte = 8'h00;
  logic in_last = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [b64e_pkg::CHAR_W-1:0] out_char;
  logic out_last;

  logic calm = 1'b0;
  int unsigned err_count = 0;
  logic [15:0] enc_held = 16'h0000;
  logic [1:0] enc_count = 2'd0;
  enc_char_t char_queue [$];
  dir_row_t dir_rows [22];

  base64_stream_encoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [b64e_pkg::CHAR_W-1:0] b64_char(input logic [5:0] s);
    return ALPHABET[8*(63-int'(s)) +: b64e_pkg::CHAR_W];
  endfunction

  task automatic flag_error(input string what, input logic [b64e_pkg::CHAR_W-1:0] got,
                            input logic [b64e_pkg::CHAR_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // advance the encoder state for one accepted request and queue the characters it yields
  task automatic encode_byte(input logic [7:0] b, input logic l, input logic typed,
                             input logic [31:0] typed_chars);
    logic [23:0] grp;
    logic [2:0] cnt;
    enc_char_t e;
    cnt = {1'b0, enc_count} + 3'd1;
    if (cnt < 3'd3 && !l) begin
      enc_held = {enc_held[7:0], b};
      enc_count = cnt[1:0];
    end else begin
      if (cnt == 3'd3) begin
        grp = {enc_held, b};
      end else if (cnt == 3'd2) begin
        grp = {enc_held[7:0], b, 8'h00};
      end else begin
        grp = {b, 16'h0000};
      end
      for (int i = 0; i < 4; i++) begin
        if (typed) begin
          e.ch = typed_chars[30-8*i -: b64e_pkg::CHAR_W];
        end else if (i <= int'(cnt)) begin
          e.ch = b64_char(grp[23-6*i -: 6]);
        end else begin
          e.ch = b64e_pkg::PAD_CHAR;
        end
        e.lst = l && (i == 3);
        char_queue.push_back(e);
      end
      enc_held = 16'h0000;
      enc_count = 2'd0;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input logic [31:0] typed_chars);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last <= l;
    do @(posedge clk); while (!in_ready);
    encode_byte(b, l, typed, typed_chars);
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    enc_char_t e;
    if (rst_n && out_valid && out_ready) begin
      if (char_queue.size() == 0) begin
        flag_error("unexpected char", out_char, '0);
      end else begin
        e = char_queue.pop_front();
        if (out_char !== e.ch) flag_error("out_char", out_char, e.ch);
        if (out_last !== e.lst) begin
          flag_error("out_last", b64e_pkg::CHAR_W'(out_last), b64e_pkg::CHAR_W'(e.lst));
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned msg_len;
    logic [7:0] b;
    logic drained;
    drained = 1'b0;
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, "AA=="},
      '{8'hFF, 1'b1, 1'b1, "/w=="},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b1, 1'b1, "//8="},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b1, 1'b1, "AAA="},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b0, 1'b0, 32'h0},
      '{8'hFF, 1'b1, 1'b1, "////"},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b0, 32'h0},
      '{8'h00, 1'b0, 1'b1, "AAAA"},
      '{8'h4D, 1'b0, 1'b0, 32'h0},
      '{8'h61, 1'b0, 1'b0, 32'h0},
      '{8'h6E, 1'b1, 1'b1, "TWFu"},
      '{8'hA5, 1'b0, 1'b0, 32'h0},
      '{8'h5A, 1'b0, 1'b0, 32'h0},
      '{8'h3C, 1'b0, 1'b0, 32'h0},
      '{8'hC3, 1'b1, 1'b0, 32'h0},
      '{8'h80, 1'b0, 1'b0, 32'h0},
      '{8'h01, 1'b1, 1'b0, 32'h0},
      '{8'h7F, 1'b1, 1'b0, 32'h0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].chars);
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      // long stretch with both sides running flat out
      calm <= (sent >= 60 && sent < 140);
      if (!drained && sent >= 180) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (char_queue.size() != 0) @(posedge clk);
      end
      msg_len = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : $urandom_range(6, 1);
      for (int k = 0; k < int'(msg_len); k++) begin
        case ($urandom_range(7))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(255));
        endcase
        send_byte(b, k == int'(msg_len) - 1, 1'b0, 32'h0);
        sent++;
      end
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    while (char_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && char_queue.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
